@@ hdl/nnm_pkg.sv @@
// Shared constants, status codes and controller/datapath interface structs
// for the neighborhood nearest-match block. No dependencies.
`default_nettype none

package nnm_pkg;

    // Pool geometry
    localparam int POOL_DEPTH = 65536;
    localparam int ADDR_W     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

    // Pixel and entry layout: ul, up, ur, left, center from the low bits up
    localparam int PIX_W      = 24;
    localparam int NBR_PIX    = 4;
    localparam int NBR_BYTES  = 3 * NBR_PIX;
    localparam int ENTRY_W    = 5 * PIX_W;
    localparam int SQ_W       = 16;
    localparam int PSUM_W     = 18;
    localparam int DIST_W     = 20;

    // Stream widths
    localparam int IN_DATA_W  = ENTRY_W;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 2;

    // Command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_STORED = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_MATCH  = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic       capture;      // latch the accepted input item
        logic       write_en;     // store the latched entry and bump the count
        logic       scan_start;   // rewind the scan index, clear the best
        logic       issue;        // read one pool entry into the pipeline
        logic       post;         // load the output register
        logic [1:0] post_status;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_query;
        logic full;
        logic empty;
        logic scan_last;
        logic pipe_busy;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ hdl/nnm_ctrl.sv @@
// Sequencer for the nearest-match block: decides loads, runs the pool scan
// and posts results. Depends on nnm_pkg.
`default_nettype none

module nnm_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire nnm_pkg::t_dp_sts i_sts,
    output nnm_pkg::t_dp_cmd     o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_POST   = 3'd4;

    logic [2:0] r_state, n_state;
    logic [1:0] r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= nnm_pkg::ST_STORED;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_state           = r_state;
        n_status          = r_status;
        o_in_ready        = 1'b0;
        o_cmd             = '0;
        o_cmd.post_status = r_status;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_POST;
                if (!i_sts.is_query) begin
                    if (i_sts.full) begin
                        n_status = nnm_pkg::ST_FULL;
                    end else begin
                        o_cmd.write_en = 1'b1;
                        n_status       = nnm_pkg::ST_STORED;
                    end
                end else if (i_sts.empty) begin
                    n_status = nnm_pkg::ST_EMPTY;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_status         = nnm_pkg::ST_MATCH;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (i_sts.out_free) begin
                    o_cmd.post = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/nnm_datapath.sv @@
// Datapath for the nearest-match block: pool memory, entry count, SSD
// pipeline, best-match tracker and output register. Depends on nnm_pkg.
`default_nettype none

module nnm_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [nnm_pkg::IN_DATA_W-1:0]     i_in_data,
    input  wire logic                              i_in_cmd,
    input  wire nnm_pkg::t_dp_cmd                  i_cmd,
    output nnm_pkg::t_dp_sts                       o_sts,
    output logic                                   o_out_valid,
    output logic [nnm_pkg::PIX_W-1:0]              o_out_pix,
    output logic [nnm_pkg::DIST_W-1:0]             o_out_dist,
    output logic [1:0]                             o_out_status,
    input  wire logic                              i_out_ready
);

    // Latched input item
    logic [nnm_pkg::ENTRY_W-1:0] r_q_data;
    logic                        r_q_cmd;

    // Pool
    logic [nnm_pkg::ENTRY_W-1:0] mem [nnm_pkg::POOL_DEPTH];
    logic [nnm_pkg::CNT_W-1:0]   r_count;
    logic [nnm_pkg::ADDR_W-1:0]  r_scan_idx;

    // Pipeline stages
    logic [nnm_pkg::ENTRY_W-1:0] r_rd_data;
    logic                        r_v0, r_v1, r_v2, r_v3, r_v4;
    logic [7:0]                  r_diff [nnm_pkg::NBR_BYTES];
    logic [nnm_pkg::SQ_W-1:0]    r_sq   [nnm_pkg::NBR_BYTES];
    logic [nnm_pkg::PSUM_W-1:0]  r_psum [nnm_pkg::NBR_PIX];
    logic [nnm_pkg::DIST_W-1:0]  r_total;
    logic [nnm_pkg::PIX_W-1:0]   r_ctr1, r_ctr2, r_ctr3, r_ctr4;

    // Best match
    logic                        r_first;
    logic [nnm_pkg::DIST_W-1:0]  r_best_dist;
    logic [nnm_pkg::PIX_W-1:0]   r_best_pix;

    // Output register
    logic                        r_out_valid;
    logic [nnm_pkg::PIX_W-1:0]   r_out_pix;
    logic [nnm_pkg::DIST_W-1:0]  r_out_dist;
    logic [1:0]                  r_out_status;

    logic [nnm_pkg::CNT_W-1:0]   n_count;
    logic [nnm_pkg::CNT_W-1:0]   w_idx_plus1;

    assign w_idx_plus1 = nnm_pkg::CNT_W'(r_scan_idx) + 1'b1;
    assign n_count     = r_count + 1'b1;

    always_comb begin
        o_sts.is_query  = (r_q_cmd == nnm_pkg::CMD_QUERY);
        o_sts.full      = (r_count == nnm_pkg::CNT_W'(nnm_pkg::POOL_DEPTH));
        o_sts.empty     = (r_count == '0);
        o_sts.scan_last = (w_idx_plus1 == r_count);
        o_sts.pipe_busy = r_v0 | r_v1 | r_v2 | r_v3 | r_v4;
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    // Capture the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_q_data <= i_in_data;
            r_q_cmd  <= i_in_cmd;
        end
    end

    // Entry count and scan index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.write_en) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_scan_idx <= '0;
        end else if (i_cmd.issue) begin
            r_scan_idx <= w_idx_plus1[nnm_pkg::ADDR_W-1:0];
        end
    end

    // Pool memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_en) begin
            mem[r_count[nnm_pkg::ADDR_W-1:0]] <= r_q_data;
        end
        if (i_cmd.issue) begin
            r_rd_data <= mem[r_scan_idx];
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v0 <= i_cmd.issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Absolute byte differences, squares, per-pixel sums, total
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < nnm_pkg::NBR_BYTES; k++) begin
            if (r_rd_data[8*k +: 8] > r_q_data[8*k +: 8]) begin
                r_diff[k] <= r_rd_data[8*k +: 8] - r_q_data[8*k +: 8];
            end else begin
                r_diff[k] <= r_q_data[8*k +: 8] - r_rd_data[8*k +: 8];
            end
            r_sq[k] <= {8'd0, r_diff[k]} * {8'd0, r_diff[k]};
        end
        for (int p = 0; p < nnm_pkg::NBR_PIX; p++) begin
            r_psum[p] <= nnm_pkg::PSUM_W'(r_sq[3*p])
                       + nnm_pkg::PSUM_W'(r_sq[3*p+1])
                       + nnm_pkg::PSUM_W'(r_sq[3*p+2]);
        end
        r_total <= nnm_pkg::DIST_W'(r_psum[0]) + nnm_pkg::DIST_W'(r_psum[1])
                 + nnm_pkg::DIST_W'(r_psum[2]) + nnm_pkg::DIST_W'(r_psum[3]);
        r_ctr1 <= r_rd_data[nnm_pkg::ENTRY_W-1 -: nnm_pkg::PIX_W];
        r_ctr2 <= r_ctr1;
        r_ctr3 <= r_ctr2;
        r_ctr4 <= r_ctr3;
    end

    // Keep the first entry with the lowest distance
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_first <= 1'b1;
        end else if (r_v4 && (r_first || r_total < r_best_dist)) begin
            r_first     <= 1'b0;
            r_best_dist <= r_total;
            r_best_pix  <= r_ctr4;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.post) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.post) begin
            r_out_status <= i_cmd.post_status;
            if (i_cmd.post_status == nnm_pkg::ST_MATCH) begin
                r_out_pix  <= r_best_pix;
                r_out_dist <= r_best_dist;
            end else begin
                r_out_pix  <= '0;
                r_out_dist <= '0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_pix    = r_out_pix;
    assign o_out_dist   = r_out_dist;
    assign o_out_status = r_out_status;

endmodule

`default_nettype wire

@@ hdl/neighborhood_nearest_match.sv @@
// Nearest-match search over a pool of pixel neighborhoods (top level).
// A load passes through the decide and post states before its result is registered;
// a query also scans every pool entry and drains the pipeline before posting.
// One item at a time: a new transfer is taken only after the result is posted;
// the single pool read port gives one entry per cycle during the scan.
// Reset empties the pool (count to zero); the memory itself is not cleared.
`default_nettype none

module neighborhood_nearest_match (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Input stream
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: upper_left_pixel, upper_pixel, upper_right_pixel, left_pixel,
    //        center_pixel (24 bits each, from bit 0 up)
    input  wire logic [nnm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: command (0 load, 1 query)
    input  wire logic [nnm_pkg::IN_USER_W-1:0]    s_axis_tuser,
    // Result stream
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // tdata: matched_pixel [23:0], best_distance [43:24], zero pad [47:44]
    output logic [nnm_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // tuser: status [1:0]
    output logic [nnm_pkg::OUT_USER_W-1:0]        m_axis_tuser
);

    nnm_pkg::t_dp_cmd              dp_cmd;
    nnm_pkg::t_dp_sts              dp_sts;
    logic [nnm_pkg::PIX_W-1:0]     out_pix;
    logic [nnm_pkg::DIST_W-1:0]    out_dist;
    logic [1:0]                    out_status;

    // Sequencer: takes one transfer at a time while idle, even with a result
    // still waiting in the output register.
    nnm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // Pool memory, five-stage distance pipeline, best tracker, output register
    nnm_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_data    (s_axis_tdata),
        .i_in_cmd     (s_axis_tuser[0]),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .o_out_valid  (m_axis_tvalid),
        .o_out_pix    (out_pix),
        .o_out_dist   (out_dist),
        .o_out_status (out_status),
        .i_out_ready  (m_axis_tready)
    );

    // Pack the result fields, low field first, zero-filled to whole bytes
    assign m_axis_tdata = {
        (nnm_pkg::OUT_DATA_W - nnm_pkg::PIX_W - nnm_pkg::DIST_W)'(0),
        out_dist,
        out_pix
    };
    assign m_axis_tuser = out_status;

    // A posted result is visible on the next cycle
    a_post_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.post |=> m_axis_tvalid)
        else $error("posted result not presented");

    // No transfer is taken while scan entries are still in the pipeline
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !dp_sts.pipe_busy)
        else $error("input ready while pipeline busy");

    // Reads only happen on a non-empty pool
    a_issue_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.issue |-> !dp_sts.empty)
        else $error("pool read while empty");

endmodule

`default_nettype wire
